// File: rtl/btwf_pkg.sv
// shared constants, types and helpers for the busiest time window finder
`default_nettype none
package btwf_pkg;

  localparam int WINDOW_DEPTH = 1024;
  localparam int PTR_W        = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int TIME_W       = 22;
  localparam int OUT_CNT_W    = 11;
  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 56;

  localparam logic [TIME_W-1:0] WINDOW_LENGTH_RESET = TIME_W'(3600);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT
  } btwf_state_t;

  typedef struct packed {
    logic                 overflow;
    logic [TIME_W-1:0]    window_last;
    logic [TIME_W-1:0]    window_first;
    logic [OUT_CNT_W-1:0] best_count;
  } btwf_result_t;

  // circular pointer advance
  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage
`default_nettype wire

// File: rtl/busiest_time_window_finder_top.sv
// busiest time window finder: event fifo in block ram, running best window tracker
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+---------------------------------------------
//  s_*     | in        | s_tvalid/s_tready| s_tdata: event_time, s_tlast: last_event
//  m_*     | out       | m_tvalid/m_tready| m_tdata: best_count, window_first, ...
//  cfg_*   | in        | cfg_wr_en        | cfg_wr_data: window_length
//
// each request is accepted in idle and then checked, one entry dropped from the
// window's old end at a time: the single read port of the fifo ram checks one
// oldest entry per cycle. the request marked last then loads the result in emit.
// rst is synchronous and clears pointers, counts and best window; ram contents
// are not cleared. a result waiting in the output register does not block new
// requests; only a second final request stalls until the first result is taken.
`default_nettype none
module busiest_time_window_finder_top (
  input  wire                          clk,
  input  wire                          rst,
  // window_length
  input  wire                          cfg_wr_en,
  input  wire [btwf_pkg::TIME_W-1:0]   cfg_wr_data,
  // s_tdata: event_time [21:0], zero pad [23:22]
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire [btwf_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire                          s_tlast,
  // m_tdata: best_count [10:0], window_first [32:11], window_last [54:33],
  //          overflow [55]
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [btwf_pkg::OUT_DATA_W-1:0] m_tdata
);
  import btwf_pkg::*;

  // control and datapath registers
  btwf_state_t       state, state_next;
  logic [TIME_W-1:0] window_length;
  logic [PTR_W-1:0]  head, head_next;
  logic [PTR_W-1:0]  tail, tail_next;
  logic [CNT_W-1:0]  occupancy, occupancy_next;
  logic [CNT_W-1:0]  best, best_next;
  logic [TIME_W-1:0] best_start, best_start_next;
  logic [TIME_W-1:0] best_end, best_end_next;
  logic              overflow_seen, overflow_seen_next;
  logic [TIME_W-1:0] cur_time;
  logic              cur_last;
  logic              out_valid, out_valid_next;
  btwf_result_t      out_data;

  // fifo ram, one write and one registered read port
  logic [TIME_W-1:0] mem [WINDOW_DEPTH];
  logic [TIME_W-1:0] rd_data;
  logic              mem_we;

  logic accept;
  logic full;
  logic pop;
  logic out_free;
  logic load_out;

  assign accept   = (state == ST_IDLE) && s_tvalid;
  assign full     = (occupancy == CNT_W'(WINDOW_DEPTH));
  assign out_free = !out_valid || m_tready;
  assign load_out = (state == ST_EMIT) && out_free;
  assign mem_we   = accept;

  // drop the oldest entry while newest minus oldest reaches the window length;
  // a zero length behaves like one and a timestamp going backwards never drops
  assign pop = (occupancy > CNT_W'(1)) && (rd_data < cur_time) &&
               ((cur_time - rd_data) >= window_length);

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!pop) begin
          state_next = cur_last ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    head_next          = head;
    tail_next          = tail;
    occupancy_next     = occupancy;
    best_next          = best;
    best_start_next    = best_start;
    best_end_next      = best_end;
    overflow_seen_next = overflow_seen;
    out_valid_next     = out_valid && !m_tready;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          // push, dropping the oldest entry first when full
          tail_next = next_slot(tail);
          if (full) begin
            head_next          = next_slot(head);
            overflow_seen_next = 1'b1;
          end else begin
            occupancy_next = occupancy + CNT_W'(1);
          end
        end
      end
      ST_CHECK: begin
        if (pop) begin
          head_next      = next_slot(head);
          occupancy_next = occupancy - CNT_W'(1);
        end else if (occupancy > best) begin
          // strict compare keeps the earlier window on a tie
          best_next       = occupancy;
          best_start_next = (occupancy == CNT_W'(1)) ? cur_time : rd_data;
          best_end_next   = cur_time;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_next     = 1'b1;
          head_next          = '0;
          tail_next          = '0;
          occupancy_next     = '0;
          best_next          = '0;
          best_start_next    = '0;
          best_end_next      = '0;
          overflow_seen_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // ram: read address follows the head so the oldest entry is ready next cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail] <= s_tdata[TIME_W-1:0];
    end
    rd_data <= mem[head_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      window_length <= WINDOW_LENGTH_RESET;
      head          <= '0;
      tail          <= '0;
      occupancy     <= '0;
      best          <= '0;
      best_start    <= '0;
      best_end      <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      head          <= head_next;
      tail          <= tail_next;
      occupancy     <= occupancy_next;
      best          <= best_next;
      best_start    <= best_start_next;
      best_end      <= best_end_next;
      overflow_seen <= overflow_seen_next;
      out_valid     <= out_valid_next;
      if (cfg_wr_en) begin
        window_length <= cfg_wr_data;
      end
    end
  end

  // request payload and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_time <= s_tdata[TIME_W-1:0];
      cur_last <= s_tlast;
    end
    if (load_out) begin
      out_data.best_count   <= OUT_CNT_W'(best);
      out_data.window_first <= best_start;
      out_data.window_last  <= best_end;
      out_data.overflow     <= overflow_seen;
    end
  end

endmodule
`default_nettype wire
